[hdl/pfm_pkg.sv]
// pfm_pkg: shared widths and constants of the period frequency meter.
// No dependencies; used by pfm_rsp_if, every pfm module and the verification files.
`timescale 1ns / 1ps
package pfm_pkg;

   localparam int FREQ_WIDTH = 16;
   localparam int DISP_WIDTH = 8;

   localparam logic [FREQ_WIDTH-1:0] NUM_RESET   = 16'd10000;
   localparam logic [FREQ_WIDTH-1:0] UPPER_LIMIT = 16'd99;
   localparam logic [FREQ_WIDTH-1:0] LOWER_LIMIT = 16'd10;
   localparam logic [DISP_WIDTH-1:0] OVER_CODE   = 8'hEE;
   localparam logic [DISP_WIDTH-1:0] LOW_CODE    = 8'h10;

   typedef logic [FREQ_WIDTH-1:0] freq_type;
   typedef logic [DISP_WIDTH-1:0] disp_type;

endpackage

[hdl/pfm_if.sv]
// pfm_if: valid/ready channel interfaces for the sample and result beats.
// Depends on pfm_pkg for payload types.
`timescale 1ns / 1ps
interface pfm_req_if;
   logic valid;
   logic ready;
   logic level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

interface pfm_rsp_if;
   logic             valid;
   logic             ready;
   pfm_pkg::freq_type frequency;
   pfm_pkg::disp_type display_code;

   modport source (output valid, output frequency, output display_code, input ready);
   modport sink   (input valid, input frequency, input display_code, output ready);
endinterface

[hdl/pfm_front.sv]
// pfm_front: edge tracking and period tick counter; pushes finished counts.
// Depends on pfm_pkg and pfm_req_if.
`timescale 1ns / 1ps
module pfm_front #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   pfm_req_if.sink                req,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [COUNT_WIDTH-1:0] push_count
);
   import pfm_pkg::*;

   localparam logic [1:0] PH_SKIP_HIGH = 2'd0;
   localparam logic [1:0] PH_SKIP_LOW  = 2'd1;
   localparam logic [1:0] PH_CNT_HIGH  = 2'd2;
   localparam logic [1:0] PH_CNT_LOW   = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] tick_up;
   logic                   accept;

   // In the counted low phase every sample waits for queue room, not only the closing rise.
   assign req.ready  = (phase_ff != PH_CNT_LOW) || push_ready;
   assign accept     = req.valid && req.ready;
   assign push_valid = req.valid && (phase_ff == PH_CNT_LOW) && req.level;
   assign push_count = tick_ff;
   assign tick_up    = (tick_ff != COUNT_MAX) ? tick_ff + COUNT_ONE : tick_ff;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      if (accept) begin
         case (phase_ff)
            PH_SKIP_HIGH: begin
               if (!req.level) phase_in = PH_SKIP_LOW;
            end
            PH_SKIP_LOW: begin
               if (req.level) begin
                  phase_in = PH_CNT_HIGH;
                  tick_in  = COUNT_ONE;
               end
            end
            PH_CNT_HIGH: begin
               if (!req.level) phase_in = PH_CNT_LOW;
               tick_in = tick_up;
            end
            PH_CNT_LOW: begin
               if (req.level) begin
                  phase_in = PH_SKIP_HIGH;
                  tick_in  = '0;
               end else begin
                  tick_in = tick_up;
               end
            end
            default: begin
               phase_in = PH_SKIP_HIGH;
               tick_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP_HIGH;
         tick_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

[hdl/pfm_queue.sv]
// pfm_queue: two-entry FIFO of period counts between front and back.
// Depends on pfm_pkg only for the common import style.
`timescale 1ns / 1ps
module pfm_queue #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import pfm_pkg::*;

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (!do_push && do_pop) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[hdl/pfm_back.sv]
// pfm_back: bit-serial restoring divider and display encoder with output register.
// Depends on pfm_pkg and pfm_rsp_if.
`timescale 1ns / 1ps
module pfm_back #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pfm_pkg::freq_type      numerator,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [COUNT_WIDTH-1:0] pop_count,
   pfm_rsp_if.source              rsp
);
   import pfm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int SW = $clog2(FREQ_WIDTH);
   localparam logic [SW-1:0] LAST_STEP = SW'(FREQ_WIDTH - 1);

   logic [1:0]             state_ff, state_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [COUNT_WIDTH-1:0] div_ff, div_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   freq_type               quo_ff, quo_in;
   logic                   out_valid_ff, out_valid_in;
   freq_type               out_freq_ff, out_freq_in;
   disp_type               out_disp_ff, out_disp_in;

   logic [COUNT_WIDTH:0]   rem_sh, rem_sub;
   logic                   fits;
   logic                   load_out;
   freq_type               result;
   logic [6:0]             f7;
   logic [14:0]            prod;
   logic [3:0]             tens;
   logic [6:0]             units;
   disp_type               disp;

   assign pop_ready = (state_ff == ST_IDLE);
   assign load_out  = (state_ff == ST_DONE) && (!out_valid_ff || rsp.ready);

   assign rem_sh  = {rem_ff, quo_ff[FREQ_WIDTH-1]};
   assign rem_sub = rem_sh - {1'b0, div_ff};
   assign fits    = (rem_sh >= {1'b0, div_ff});

   // Zero divisor cannot come from the front, but maps to zero anyway.
   assign result = (div_ff != '0) ? quo_ff : '0;

   // Tens digit for 11..99 by reciprocal: f*205 >> 11 is exact below 1029.
   assign f7    = result[6:0];
   assign prod  = 15'(f7) * 15'd205;
   assign tens  = prod[14:11];
   assign units = f7 - 7'(tens) * 7'd10;

   always_comb begin
      if (result > UPPER_LIMIT)       disp = OVER_CODE;
      else if (result <= LOWER_LIMIT) disp = LOW_CODE;
      else                            disp = {tens, units[3:0]};
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               div_in   = pop_count;
               rem_in   = '0;
               quo_in   = numerator;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = fits ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
            quo_in  = {quo_ff[FREQ_WIDTH-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_freq_in  = out_freq_ff;
      out_disp_in  = out_disp_ff;
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_freq_in  = result;
         out_disp_in  = disp;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      out_freq_ff <= out_freq_in;
      out_disp_ff <= out_disp_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.frequency    = out_freq_ff;
   assign rsp.display_code = out_disp_ff;

endmodule

[hdl/period_frequency_meter.sv]
// period_frequency_meter: top level, numerator register and front/queue/back.
// Depends on pfm_pkg, pfm_if, pfm_front, pfm_queue and pfm_back.
`timescale 1ns / 1ps
// Reciprocal frequency meter on a sampled level. Each req beat carries one
// sample; the front takes one beat per clock while req ready is high. After
// skipping the current high part and the following low part it counts one
// high and one low phase; the next rising sample closes the measurement and
// pushes the tick count (which saturates at 2^COUNT_WIDTH-1) into a
// two-entry queue. That same sample starts the next skip, so every other
// period is measured. The back pops a count and runs a one-bit-per-clock
// restoring division of the numerator register by it, then encodes the
// display byte (0xEE above 99, 0x10 at 10 or below, else packed BCD) into
// the output register and returns to idle to pop the next count. The rsp
// beat waits in an output register while the back starts the next count.
// req ready drops while the low phase is being counted and the queue is
// full. csr writes land in the numerator register; write it only idle.
module period_frequency_meter #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   pfm_req_if.sink           req_bus,
   pfm_rsp_if.source         rsp_bus,
   input  logic              csr_wr_en,
   input  pfm_pkg::freq_type csr_wr_data
);
   import pfm_pkg::*;

   // Dividend register; read directly by the back.
   freq_type numerator_ff, numerator_in;

   // Front to queue.
   logic                   push_valid, push_ready;
   logic [COUNT_WIDTH-1:0] push_count;

   // Queue to back.
   logic                   pop_valid, pop_ready;
   logic [COUNT_WIDTH-1:0] pop_count;

   assign numerator_in = csr_wr_en ? csr_wr_data : numerator_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         numerator_ff <= NUM_RESET;
      end else begin
         numerator_ff <= numerator_in;
      end
   end

   pfm_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_count (push_count)
   );

   pfm_queue #(.WIDTH(COUNT_WIDTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_count),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_count)
   );

   pfm_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .numerator  (numerator_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_count  (pop_count),
      .rsp        (rsp_bus)
   );

endmodule

[verif/pfm_checker.sv]
// pfm_checker: watches the sample, result and csr ports of the period frequency meter,
// predicts each reading and compares it with the result beats.
// Depends on pfm_pkg and the channel interfaces in pfm_if.
`timescale 1ns / 1ps
module pfm_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   pfm_req_if                req_bus,
   pfm_rsp_if                rsp_bus,
   input  logic              csr_wr_en,
   input  pfm_pkg::freq_type csr_wr_data,
   output int                fail_count,
   output int                pending_count,
   output int                reading_count
);
   import pfm_pkg::*;

   typedef enum logic [1:0] {SKIP_HIGH, SKIP_LOW, COUNT_HIGH, COUNT_LOW} meter_phase_type;

   typedef struct packed {
      freq_type frequency;
      disp_type display_code;
   } reading_type;

   localparam logic [COUNT_WIDTH-1:0] TICK_MAX = '1;

   meter_phase_type        meter_phase;
   logic [COUNT_WIDTH-1:0] tick_total;
   freq_type               numerator;
   reading_type            pending_readings[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] t);
      return (t == TICK_MAX) ? t : t + 1'b1;
   endfunction

   function automatic disp_type display_for(input freq_type f);
      logic [3:0] tens;
      logic [3:0] ones;
      if (f > UPPER_LIMIT) return OVER_CODE;
      if (f <= LOWER_LIMIT) return LOW_CODE;
      tens = 4'(f / 10);
      ones = 4'(f % 10);
      return {tens, ones};
   endfunction

   // One sample through the period state machine; a rise in COUNT_LOW closes a reading.
   task automatic advance_meter(input logic level);
      reading_type     r;
      longint unsigned q;
      case (meter_phase)
         SKIP_HIGH: if (!level) meter_phase = SKIP_LOW;
         SKIP_LOW: if (level) begin
            meter_phase = COUNT_HIGH;
            tick_total  = COUNT_WIDTH'(1);
         end
         COUNT_HIGH: begin
            if (!level) meter_phase = COUNT_LOW;
            tick_total = sat_inc(tick_total);
         end
         default: if (!level) begin
            tick_total = sat_inc(tick_total);
         end else begin
            q              = (tick_total != 0) ? numerator / tick_total : 0;
            r.frequency    = freq_type'(q);
            r.display_code = display_for(r.frequency);
            pending_readings.push_back(r);
            reading_count++;
            meter_phase = SKIP_HIGH;
            tick_total  = '0;
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      reading_type want;
      if (reset) begin
         meter_phase = SKIP_HIGH;
         tick_total  = '0;
         numerator   = NUM_RESET;
         pending_readings.delete();
      end else begin
         if (csr_wr_en) numerator = csr_wr_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_readings.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing pending, frequency %h",
                                         rsp_bus.frequency));
            end else begin
               want = pending_readings.pop_front();
               if (rsp_bus.frequency !== want.frequency)
                  report_mismatch($sformatf("frequency expected %h got %h",
                                            want.frequency, rsp_bus.frequency));
               if (rsp_bus.display_code !== want.display_code)
                  report_mismatch($sformatf("display_code expected %h got %h",
                                            want.display_code, rsp_bus.display_code));
            end
         end
         if (req_bus.valid && req_bus.ready) advance_meter(req_bus.level);
      end
      pending_count = pending_readings.size();
   end

endmodule

[verif/testbench.sv]
// testbench: stimulus and verdict for period_frequency_meter.
// Depends on pfm_pkg, pfm_if, the RTL under hdl/ and pfm_checker.
`timescale 1ns / 1ps
module testbench;
   import pfm_pkg::*;

   localparam int COUNT_WIDTH    = 16;
   // back part divides each reading serially; leave margin before csr writes
   localparam int SETTLE_CYCLES  = 40;
   // minimum number of samples sent per numerator setting
   localparam int PHASE_SAMPLES  = 85;
   localparam int PHASE_COUNT    = 8;
   // directed periods and the length of the alternating burst
   localparam int DIR_COUNT      = 3;
   localparam int DIR_HIGH [DIR_COUNT] = '{1, 50, 50};
   localparam int DIR_LOW  [DIR_COUNT] = '{1, 51, 50};
   localparam int BURST_SAMPLES  = 48;

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   freq_type csr_wr_data;

   int fail_count;
   int pending_count;
   int reading_count;
   int sent_samples;
   bit idle_on;   // sender may insert gaps between beats

   pfm_req_if req_bus ();
   pfm_rsp_if rsp_bus ();

   period_frequency_meter #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pfm_checker #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .reading_count (reading_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop; the slowest legal run is well under half of this.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Result side backpressure: mostly ready, short stalls, a few long ones.
   // Ready changes only at falling edges, once per step.
   initial begin : rsp_stall
      int pick;
      int len;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            rsp_bus.ready <= 1'b1;
            len = $urandom_range(50, 200);
         end else if (pick < 55) begin
            rsp_bus.ready <= 1'b1;
            len = $urandom_range(1, 20);
         end else if (pick < 92) begin
            rsp_bus.ready <= 1'b0;
            len = $urandom_range(1, 3);
         end else begin
            rsp_bus.ready <= 1'b0;
            len = $urandom_range(10, 40);
         end
         repeat (len) @(negedge clock);
      end
   end

   // One sample beat. Entered and left at a falling edge. An optional gap drops
   // valid first; otherwise valid stays high straight into the next beat.
   task automatic send_sample(input logic lvl);
      int gap;
      int pick;
      gap = 0;
      if (idle_on) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95)      gap = $urandom_range(8, 30);
         else if (pick >= 70) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.level <= lvl;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_samples++;
   endtask

   task automatic send_run(input logic lvl, input int len);
      repeat (len) send_sample(lvl);
   endtask

   // Stop sending, let every pending reading come out, then give the back
   // part time to go idle so a csr write cannot land mid-division.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      // Directed periods: the shortest legal period (one high, one low tick),
      // then counts on both sides of the top of the BCD window at the reset
      // numerator (101 -> 99, 100 -> 100). An alternating burst then closes a
      // reading every four beats, faster than the back divides, so the queue
      // fills and req ready drops.
      freq_type numerators [PHASE_COUNT];
      int       start_samples;
      int       pick;
      int       len;
      int       left;
      logic     lvl;

      req_bus.valid = 1'b0;
      req_bus.level = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      reset         = 1'b1;
      sent_samples  = 0;
      idle_on       = 1'b1;

      // Phase 0 runs on the reset value; the rest cover both extremes, zero,
      // a rewrite of the reset value and random settings.
      numerators[0] = NUM_RESET;
      numerators[1] = 16'hFFFF;
      numerators[2] = 16'd1;
      numerators[3] = 16'd0;
      numerators[4] = freq_type'($urandom_range(1, 65535));
      numerators[5] = freq_type'($urandom_range(2, 2000));
      numerators[6] = NUM_RESET;
      numerators[7] = freq_type'($urandom_range(20000, 65535));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Start inside a high part so the initial skip of the high phase is hit.
      send_run(1'b1, 2);
      for (int m = 0; m < DIR_COUNT; m++) begin
         send_run(1'b0, 1);
         send_run(1'b1, DIR_HIGH[m]);
         send_run(1'b0, DIR_LOW[m]);
         send_run(1'b1, 1);   // closing rise, also starts the next skip
      end

      idle_on = 1'b0;
      for (int k = 0; k < BURST_SAMPLES; k++) send_sample(1'(k % 2));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            // sender holds off here until every reading is out
            wait_drained();
            csr_wr_en   <= 1'b1;
            csr_wr_data <= numerators[p];
            @(negedge clock);
            csr_wr_en   <= 1'b0;
         end
         // roughly one phase in four runs with no sender gaps at all
         idle_on       = ($urandom_range(0, 3) != 0);
         start_samples = sent_samples;
         lvl           = 1'b1;
         while (sent_samples - start_samples < PHASE_SAMPLES) begin
            left = PHASE_SAMPLES - (sent_samples - start_samples);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // noise: a burst of random samples, breaks up the run pattern
               repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
            end else begin
               // well-formed run of one level, mostly short, a few long
               pick = $urandom_range(0, 99);
               if (pick < 65)      len = $urandom_range(1, 4);
               else if (pick < 92) len = $urandom_range(5, 20);
               else                len = $urandom_range(21, 100);
               if (len > left) len = left;
               if (len > 20 && idle_on) begin
                  idle_on = 1'b0;
                  send_run(lvl, len);
                  idle_on = 1'b1;
               end else begin
                  send_run(lvl, len);
               end
               lvl = ~lvl;
            end
         end
      end

      wait_drained();
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
